// ===== hdl/hrt_pkg.sv =====
// Package for the HTTP request tokenizer: codes, state and result types, helper functions.
`timescale 1ns / 1ps
`default_nettype none

package hrt_pkg;

	localparam int unsigned MaxResults = 3;

	// Result kinds.
	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;
	localparam logic [1:0] KIND_BAD  = 2'd3;

	// Field codes, also used as the parse phase.
	localparam logic [2:0] FLD_METHOD  = 3'd0;
	localparam logic [2:0] FLD_URL     = 3'd1;
	localparam logic [2:0] FLD_VERSION = 3'd2;
	localparam logic [2:0] FLD_KEY     = 3'd3;
	localparam logic [2:0] FLD_VALUE   = 3'd4;

	// Percent escape progress.
	localparam logic [1:0] PCT_NONE  = 2'd0;
	localparam logic [1:0] PCT_SIGN  = 2'd1;
	localparam logic [1:0] PCT_DIGIT = 2'd2;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_COLON = 8'h3A;

	typedef struct packed {
		logic [2:0] phase;
		logic       pending_cr;
		logic       pending_colon;
		logic [1:0] percent_stage;
		logic [7:0] held_hex_char;
		logic       key_seen;
		logic       value_seen;
	} hrt_state_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] field;
		logic [7:0] data;
		logic       keep;
	} hrt_res_t;

	typedef struct packed {
		logic [1:0]                count;
		hrt_res_t [MaxResults-1:0] r;
	} hrt_batch_t;

	localparam hrt_state_t STATE_RESET = '{
		phase:         FLD_METHOD,
		pending_cr:    1'b0,
		pending_colon: 1'b0,
		percent_stage: PCT_NONE,
		held_hex_char: 8'h00,
		key_seen:      1'b0,
		value_seen:    1'b0
	};

	function automatic hrt_res_t mk_res(logic [1:0] kind, logic [2:0] field,
			logic [7:0] data, logic keep);
		hrt_res_t r;
		r.kind  = kind;
		r.field = field;
		r.data  = data;
		r.keep  = keep;
		return r;
	endfunction

	// Bit 4 flags a hex digit of either case, bits 3:0 give its value.
	function automatic logic [4:0] hex_digit(logic [7:0] c);
		logic [4:0] v;
		v = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = {1'b1, 4'(c - 8'h37)};
		end
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/hrt_step.sv =====
// Combinational step of the tokenizer: one byte and the parse state give the next state and results.
`timescale 1ns / 1ps
`default_nettype none

module hrt_step import hrt_pkg::*; (
	input  wire logic [7:0] in_byte,
	input  wire hrt_state_t cur,
	output hrt_state_t      nxt,
	output hrt_batch_t      batch
);

	always_comb begin
		hrt_state_t st;
		hrt_batch_t bt;
		logic       run;
		logic       done;
		logic [4:0] hb;
		logic [4:0] hh;
		logic       flush;

		st   = cur;
		bt   = '0;
		run  = 1'b1;
		done = 1'b0;
		flush = 1'b0;
		hb   = hex_digit(in_byte);
		hh   = hex_digit(cur.held_hex_char);

		if (st.pending_cr) begin
			st.pending_cr = 1'b0;
			if (in_byte == CH_LF) begin
				run = 1'b0;
				case (st.phase)
					FLD_VERSION: begin
						bt.r[bt.count] = mk_res(KIND_END, FLD_VERSION, 8'h00, 1'b0);
						bt.count = bt.count + 2'd1;
						st.phase = FLD_KEY;
						st.key_seen = 1'b0;
						st.value_seen = 1'b0;
					end
					FLD_KEY: begin
						bt.r[bt.count] = mk_res(KIND_DONE, FLD_METHOD, 8'h00, 1'b0);
						bt.count = bt.count + 2'd1;
						st = STATE_RESET;
					end
					FLD_VALUE: begin
						bt.r[bt.count] = mk_res(KIND_END, FLD_VALUE, 8'h00,
							st.key_seen & st.value_seen);
						bt.count = bt.count + 2'd1;
						st.phase = FLD_KEY;
						st.key_seen = 1'b0;
						st.value_seen = 1'b0;
					end
					default: begin
						bt.r[bt.count] = mk_res(KIND_BAD, FLD_METHOD, 8'h00, 1'b0);
						bt.count = bt.count + 2'd1;
						st = STATE_RESET;
					end
				endcase
			end else begin
				// The held CR turns out to be data of the current field.
				bt.r[bt.count] = mk_res(KIND_DATA, st.phase, CH_CR, 1'b0);
				bt.count = bt.count + 2'd1;
				if (st.phase == FLD_KEY) st.key_seen = 1'b1;
				if (st.phase == FLD_VALUE) st.value_seen = 1'b1;
			end
		end

		if (run) begin
			if (in_byte == CH_CR) begin
				if (st.phase == FLD_URL) begin
					if (st.percent_stage != PCT_NONE) begin
						bt.r[bt.count] = mk_res(KIND_DATA, FLD_URL, CH_PCT, 1'b0);
						bt.count = bt.count + 2'd1;
					end
					if (st.percent_stage == PCT_DIGIT) begin
						bt.r[bt.count] = mk_res(KIND_DATA, FLD_URL, st.held_hex_char, 1'b0);
						bt.count = bt.count + 2'd1;
					end
					st.percent_stage = PCT_NONE;
				end
				if (st.pending_colon) begin
					bt.r[bt.count] = mk_res(KIND_DATA, st.phase, CH_COLON, 1'b0);
					bt.count = bt.count + 2'd1;
					if (st.phase == FLD_KEY) st.key_seen = 1'b1;
					if (st.phase == FLD_VALUE) st.value_seen = 1'b1;
					st.pending_colon = 1'b0;
				end
				st.pending_cr = 1'b1;
			end else begin
				case (st.phase)
					FLD_METHOD: begin
						if (in_byte == CH_SP) begin
							bt.r[bt.count] = mk_res(KIND_END, FLD_METHOD, 8'h00, 1'b0);
							bt.count = bt.count + 2'd1;
							st.phase = FLD_URL;
						end else begin
							bt.r[bt.count] = mk_res(KIND_DATA, FLD_METHOD, in_byte, 1'b0);
							bt.count = bt.count + 2'd1;
						end
					end
					FLD_URL: begin
						// A broken escape gives back the percent sign and held digit first.
						if (st.percent_stage == PCT_SIGN) begin
							if (hb[4]) begin
								st.held_hex_char = in_byte;
								st.percent_stage = PCT_DIGIT;
								done = 1'b1;
							end else begin
								flush = 1'b1;
							end
						end else if (st.percent_stage == PCT_DIGIT) begin
							if (hb[4] && hh[4]) begin
								st.percent_stage = PCT_NONE;
								bt.r[bt.count] = mk_res(KIND_DATA, FLD_URL, {hh[3:0], hb[3:0]},
									1'b0);
								bt.count = bt.count + 2'd1;
								done = 1'b1;
							end else begin
								flush = 1'b1;
							end
						end
						if (flush) begin
							bt.r[bt.count] = mk_res(KIND_DATA, FLD_URL, CH_PCT, 1'b0);
							bt.count = bt.count + 2'd1;
							if (st.percent_stage == PCT_DIGIT) begin
								bt.r[bt.count] = mk_res(KIND_DATA, FLD_URL, st.held_hex_char,
									1'b0);
								bt.count = bt.count + 2'd1;
							end
							st.percent_stage = PCT_NONE;
						end
						if (!done) begin
							if (in_byte == CH_PCT) begin
								st.percent_stage = PCT_SIGN;
							end else if (in_byte == CH_SP) begin
								bt.r[bt.count] = mk_res(KIND_END, FLD_URL, 8'h00, 1'b0);
								bt.count = bt.count + 2'd1;
								st.phase = FLD_VERSION;
							end else begin
								bt.r[bt.count] = mk_res(KIND_DATA, FLD_URL, in_byte, 1'b0);
								bt.count = bt.count + 2'd1;
							end
						end
					end
					FLD_VERSION, FLD_VALUE: begin
						bt.r[bt.count] = mk_res(KIND_DATA, st.phase, in_byte, 1'b0);
						bt.count = bt.count + 2'd1;
						if (st.phase == FLD_VALUE) st.value_seen = 1'b1;
					end
					FLD_KEY: begin
						if (st.pending_colon) begin
							st.pending_colon = 1'b0;
							if (in_byte == CH_SP) begin
								bt.r[bt.count] = mk_res(KIND_END, FLD_KEY, 8'h00, 1'b0);
								bt.count = bt.count + 2'd1;
								st.phase = FLD_VALUE;
								done = 1'b1;
							end else begin
								bt.r[bt.count] = mk_res(KIND_DATA, FLD_KEY, CH_COLON, 1'b0);
								bt.count = bt.count + 2'd1;
								st.key_seen = 1'b1;
							end
						end
						if (!done) begin
							if (in_byte == CH_COLON) begin
								st.pending_colon = 1'b1;
							end else begin
								bt.r[bt.count] = mk_res(KIND_DATA, FLD_KEY, in_byte, 1'b0);
								bt.count = bt.count + 2'd1;
								st.key_seen = 1'b1;
							end
						end
					end
					default: begin
						st = STATE_RESET;
					end
				endcase
			end
		end

		nxt   = st;
		batch = bt;
	end

endmodule

`default_nettype wire

// ===== hdl/http_request_tokenizer_core.sv =====
// Top level of the HTTP request tokenizer: parse state, step logic and result buffer.
// Latency: the first result of a byte is offered in the cycle after its beat is accepted.
// Throughput: a byte takes as many output beats as it yields results (zero to three);
// a new byte is accepted in every cycle while each byte yields at most one result and the
// output is not stalled, since the result buffer drives a single output beat per cycle.
// Reset (arst_n low) returns parsing to the method field and drops buffered results.
`timescale 1ns / 1ps
`default_nettype none

module http_request_tokenizer_core import hrt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [7:0] out_byte, [8] keep, [15:9] zero
	output logic [4:0]       m_tuser,   // [1:0] kind, [4:2] field
	output logic             m_tlast
);

	hrt_state_t                state_q;
	hrt_state_t                state_nxt;
	hrt_batch_t                batch;
	hrt_res_t [MaxResults-1:0] buf_q;
	logic [1:0]                rem_q;
	logic                      acc;
	logic                      pop;

	hrt_step u_step (
		.in_byte (s_tdata),
		.cur     (state_q),
		.nxt     (state_nxt),
		.batch   (batch)
	);

	assign m_tvalid = (rem_q != 2'd0);
	assign pop      = m_tvalid & m_tready;
	// Room for a new batch once the buffer is empty or its last beat leaves now.
	assign s_tready = (rem_q == 2'd0) || ((rem_q == 2'd1) && m_tready);
	assign acc      = s_tvalid & s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
			rem_q   <= 2'd0;
		end else begin
			if (acc) begin
				state_q <= state_nxt;
				rem_q   <= batch.count;
			end else if (pop) begin
				rem_q   <= rem_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			buf_q <= batch.r;
		end else if (pop) begin
			buf_q[0] <= buf_q[1];
			buf_q[1] <= buf_q[2];
		end
	end

	assign m_tdata = {7'd0, buf_q[0].keep, buf_q[0].data};
	assign m_tuser = {buf_q[0].field, buf_q[0].kind};
	assign m_tlast = (rem_q == 2'd1);

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Testbench for the HTTP request tokenizer: byte stream driver, result checker and predictor.
`timescale 1ns / 1ps

module tb_top;
	import hrt_pkg::*;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] fld;
		logic [7:0] data;
		logic       keep;
		logic       last;
	} token_t;

	typedef struct {
		logic [7:0] b;
		bit         drain;
	} req_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [4:0]  m_tuser;
	logic        m_tlast;

	req_byte_t   req_bytes[$];
	token_t      expected_tokens[$];
	token_t      step_tokens[$];

	// Parser state of the predictor.
	logic [2:0]  p_phase;
	logic        p_cr_held;
	logic        p_colon_held;
	logic [1:0]  p_pct;
	logic [7:0]  p_hex_held;
	logic        p_key_nz;
	logic        p_val_nz;

	bit          in_fire;
	int unsigned tx_gap, tx_calm, rx_stall, rx_calm;
	int unsigned n_bytes, n_tokens, n_errors;
	int unsigned n_kind[4];

	http_request_tokenizer_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic void tok_clear();
		p_phase      = FLD_METHOD;
		p_cr_held    = 1'b0;
		p_colon_held = 1'b0;
		p_pct        = PCT_NONE;
		p_hex_held   = 8'h00;
		p_key_nz     = 1'b0;
		p_val_nz     = 1'b0;
	endfunction

	function automatic void tok_emit(logic [1:0] kind, logic [2:0] fld, logic [7:0] data,
			logic keep);
		token_t t;
		if (step_tokens.size() < MaxResults) begin
			t.kind = kind;
			t.fld  = fld;
			t.data = data;
			t.keep = keep;
			t.last = 1'b0;
			step_tokens.push_back(t);
		end
	endfunction

	function automatic void tok_data(logic [7:0] b);
		if (p_phase == FLD_KEY) p_key_nz = 1'b1;
		if (p_phase == FLD_VALUE) p_val_nz = 1'b1;
		tok_emit(KIND_DATA, p_phase, b, 1'b0);
	endfunction

	function automatic bit is_hex(logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic [3:0] hex_nib(logic [7:0] c);
		if (c >= "a") return 4'(c - "a" + 8'd10);
		if (c >= "A") return 4'(c - "A" + 8'd10);
		return 4'(c - "0");
	endfunction

	// A failed escape gives back the percent sign and any held digit as plain data.
	function automatic void tok_flush_pct();
		if (p_pct != PCT_NONE) tok_data(CH_PCT);
		if (p_pct == PCT_DIGIT) tok_data(p_hex_held);
		p_pct = PCT_NONE;
	endfunction

	function automatic void tok_url_plain(logic [7:0] b);
		if (b == CH_PCT) begin
			p_pct = PCT_SIGN;
		end else if (b == CH_SP) begin
			tok_emit(KIND_END, FLD_URL, 8'h00, 1'b0);
			p_phase = FLD_VERSION;
		end else begin
			tok_data(b);
		end
	endfunction

	function automatic void tok_line_end();
		case (p_phase)
			FLD_VERSION: begin
				tok_emit(KIND_END, FLD_VERSION, 8'h00, 1'b0);
				p_phase  = FLD_KEY;
				p_key_nz = 1'b0;
				p_val_nz = 1'b0;
			end
			FLD_KEY: begin
				tok_emit(KIND_DONE, FLD_METHOD, 8'h00, 1'b0);
				tok_clear();
			end
			FLD_VALUE: begin
				tok_emit(KIND_END, FLD_VALUE, 8'h00, p_key_nz && p_val_nz);
				p_phase  = FLD_KEY;
				p_key_nz = 1'b0;
				p_val_nz = 1'b0;
			end
			default: begin
				tok_emit(KIND_BAD, FLD_METHOD, 8'h00, 1'b0);
				tok_clear();
			end
		endcase
	endfunction

	function automatic void tok_byte(logic [7:0] b);
		if (b == CH_CR) begin
			if (p_phase == FLD_URL) tok_flush_pct();
			if (p_colon_held) begin
				tok_data(CH_COLON);
				p_colon_held = 1'b0;
			end
			p_cr_held = 1'b1;
			return;
		end
		case (p_phase)
			FLD_METHOD: begin
				if (b == CH_SP) begin
					tok_emit(KIND_END, FLD_METHOD, 8'h00, 1'b0);
					p_phase = FLD_URL;
				end else begin
					tok_data(b);
				end
			end
			FLD_URL: begin
				if (p_pct == PCT_NONE) begin
					tok_url_plain(b);
				end else if (is_hex(b) && p_pct == PCT_SIGN) begin
					p_hex_held = b;
					p_pct      = PCT_DIGIT;
				end else if (is_hex(b)) begin
					p_pct = PCT_NONE;
					tok_data({hex_nib(p_hex_held), hex_nib(b)});
				end else begin
					tok_flush_pct();
					tok_url_plain(b);
				end
			end
			FLD_VERSION, FLD_VALUE: begin
				tok_data(b);
			end
			FLD_KEY: begin
				if (p_colon_held) begin
					p_colon_held = 1'b0;
					if (b == CH_SP) begin
						tok_emit(KIND_END, FLD_KEY, 8'h00, 1'b0);
						p_phase = FLD_VALUE;
						return;
					end
					tok_data(CH_COLON);
				end
				if (b == CH_COLON) p_colon_held = 1'b1;
				else tok_data(b);
			end
			default: begin
				tok_clear();
			end
		endcase
	endfunction

	function automatic void tok_predict(logic [7:0] b);
		step_tokens.delete();
		if (p_cr_held) begin
			p_cr_held = 1'b0;
			if (b == CH_LF) begin
				tok_line_end();
			end else begin
				tok_data(CH_CR);
				tok_byte(b);
			end
		end else begin
			tok_byte(b);
		end
		if (step_tokens.size() != 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
		foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
	endfunction

	function automatic void add_byte(logic [7:0] b);
		req_byte_t e;
		e.b     = b;
		e.drain = 1'b0;
		req_bytes.push_back(e);
	endfunction

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++) add_byte(s[i]);
	endfunction

	function automatic void add_crlf();
		add_byte(CH_CR);
		add_byte(CH_LF);
	endfunction

	// Printable token character without space, colon or percent sign.
	function automatic logic [7:0] rand_tok_char();
		logic [7:0] c;
		c = 8'($urandom_range(33, 126));
		while (c == CH_COLON || c == CH_PCT) c = 8'($urandom_range(33, 126));
		return c;
	endfunction

	function automatic logic [7:0] rand_hex_char();
		int unsigned v;
		v = $urandom_range(0, 15);
		if (v < 10) return 8'("0" + v);
		if ($urandom_range(0, 1) == 0) return 8'("A" + v - 10);
		return 8'("a" + v - 10);
	endfunction

	function automatic logic [7:0] rand_value_char();
		logic [7:0] c;
		if ($urandom_range(0, 9) != 0) return 8'($urandom_range(32, 126));
		c = 8'($urandom);
		while (c == CH_CR) c = 8'($urandom);
		return c;
	endfunction

	function automatic void add_request();
		int unsigned r;
		logic [7:0]  c;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			// Noise with a bias toward the characters that steer the parser.
			repeat ($urandom_range(1, 12)) begin
				case ($urandom_range(0, 5))
					0: c = CH_SP;
					1: c = CH_CR;
					2: c = CH_LF;
					3: c = CH_COLON;
					4: c = CH_PCT;
					default: c = 8'($urandom);
				endcase
				add_byte(c);
			end
			add_crlf();
			return;
		end
		if (r < 16) begin
			repeat ($urandom_range(0, 5)) add_byte(rand_tok_char());
			if ($urandom_range(0, 1) == 0) begin
				add_byte(CH_SP);
				repeat ($urandom_range(0, 4)) add_byte(rand_tok_char());
			end
			add_crlf();
			return;
		end
		repeat ($urandom_range(1, 6)) add_byte(rand_tok_char());
		add_byte(CH_SP);
		add_byte("/");
		repeat ($urandom_range(0, 10)) begin
			r = $urandom_range(0, 9);
			if (r < 5) begin
				add_byte(rand_tok_char());
			end else if (r < 8) begin
				add_byte(CH_PCT);
				add_byte(rand_hex_char());
				add_byte(rand_hex_char());
			end else begin
				add_byte(CH_PCT);
				if (r == 9) add_byte(rand_hex_char());
				add_byte(8'($urandom_range(8'h67, 8'h7A)));
			end
		end
		if ($urandom_range(0, 9) == 0) add_byte(CH_PCT);
		add_byte(CH_SP);
		add_text("HTTP/1.1");
		if ($urandom_range(0, 9) == 0) add_text(" x");
		add_crlf();
		repeat ($urandom_range(0, 4)) begin
			repeat ($urandom_range(0, 6)) begin
				if ($urandom_range(0, 9) == 0) add_byte(CH_COLON);
				add_byte(rand_tok_char());
			end
			add_byte(CH_COLON);
			add_byte(CH_SP);
			repeat ($urandom_range(0, 8)) begin
				if ($urandom_range(0, 19) == 0) begin
					add_byte(CH_CR);
					add_byte(rand_tok_char());
				end else begin
					add_byte(rand_value_char());
				end
			end
			add_crlf();
		end
		if ($urandom_range(0, 9) < 8) begin
			add_crlf();
		end else begin
			repeat ($urandom_range(1, 4)) add_byte(rand_tok_char());
			add_crlf();
		end
	endfunction

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic void check_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s: expected %0h, got %0h", name, exp_val, act_val);
			n_errors++;
		end
	endfunction

	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_fire)) begin
			if (tx_gap != 0) begin
				tx_gap--;
				s_tvalid <= 1'b0;
			end else if (req_bytes.size() != 0 &&
					(!req_bytes[0].drain || expected_tokens.size() == 0)) begin
				s_tdata  <= req_bytes[0].b;
				s_tvalid <= 1'b1;
				req_bytes.delete(0);
				if (tx_calm != 0) begin
					tx_calm--;
				end else begin
					tx_gap = pick_gap();
					if ($urandom_range(0, 49) == 0) tx_calm = $urandom_range(20, 60);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (rx_stall != 0) begin
				rx_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (rx_calm != 0) rx_calm--;
				else if ($urandom_range(0, 3) == 0) rx_stall = pick_gap();
				else if ($urandom_range(0, 49) == 0) rx_calm = $urandom_range(20, 80);
			end
		end
	end

	// Results are checked before the byte accepted at the same edge is predicted.
	always @(posedge clk) begin
		token_t exp_tok;
		in_fire = arst_n && s_tvalid && s_tready;
		if (arst_n && m_tvalid && m_tready) begin
			n_tokens++;
			if (expected_tokens.size() == 0) begin
				$error("unexpected result: kind %0h field %0h out_byte %0h",
					m_tuser[1:0], m_tuser[4:2], m_tdata[7:0]);
				n_errors++;
			end else begin
				exp_tok = expected_tokens.pop_front();
				n_kind[exp_tok.kind]++;
				check_field("kind", 8'(exp_tok.kind), 8'(m_tuser[1:0]));
				check_field("field", 8'(exp_tok.fld), 8'(m_tuser[4:2]));
				check_field("out_byte", exp_tok.data, m_tdata[7:0]);
				check_field("keep", 8'(exp_tok.keep), 8'(m_tdata[8]));
				check_field("last", 8'(exp_tok.last), 8'(m_tlast));
				check_field("tdata pad", 8'h00, 8'(m_tdata[15:9]));
			end
		end
		if (in_fire) begin
			n_bytes++;
			tok_predict(s_tdata);
		end
	end

	initial begin
		tok_clear();
		// Empty request line, then a request line with no space at all.
		add_crlf();
		add_byte(8'hFF);
		add_crlf();
		// Escape cut short by a CR, and that CR turning out to be a lone one.
		add_text("G /%4");
		add_byte(CH_CR);
		add_byte(8'h00);
		add_text(" V");
		add_crlf();
		// Key with a lone colon and an empty value, then a line that ends the request.
		add_text("k:x: ");
		add_crlf();
		add_text("z");
		add_crlf();
		while (req_bytes.size() < 525) add_request();
		req_bytes[$urandom_range(100, 200)].drain = 1'b1;
		req_bytes[$urandom_range(300, 450)].drain = 1'b1;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (req_bytes.size() != 0 || s_tvalid) @(posedge clk);
		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d request bytes and checked %0d results:", n_bytes, n_tokens);
		$display("  %0d data, %0d field ends, %0d requests done, %0d malformed lines.",
			n_kind[KIND_DATA], n_kind[KIND_END], n_kind[KIND_DONE], n_kind[KIND_BAD]);
		if (n_errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
